// ===== src/ffpa_pkg.sv =====
// Shared types and constants for the first-fit partition allocator.
`timescale 1ns / 1ps

package ffpa_pkg;

    // Owner code of an empty partition (ASCII underscore).
    localparam logic [7:0] FREE_CODE = 8'd95;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Request modes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Byte accumulator width: holds one partition of up to 65536 bytes and
    // saturates above any 16-bit request size.
    localparam int ACC_W = 17;

    // Control from the sequencer to the ring of table cells.
    typedef struct packed {
        logic       shift;   // rotate the ring by one entry
        logic       wr;      // replace the head entry on its way to the tail
        logic [7:0] wdata;   // owner code written when wr is set
    } ring_ctl_t;

endpackage

// ===== src/ffpa_cell.sv =====
// One owner-table entry in the rotating ring of cells.
`timescale 1ns / 1ps

module ffpa_cell
    import ffpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic [7:0] d,
    output logic [7:0] q
);

    logic [7:0] entry_reg;

    // Every entry starts out free; on a shift it takes its neighbour's entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= FREE_CODE;
        end
        else if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

// ===== src/ffpa_ctrl.sv =====
// Request sequencer: scans the ring head, places or clears runs, holds the result.
`timescale 1ns / 1ps

module ffpa_ctrl
    import ffpa_pkg::*;
#(
    parameter int NUM_ENTRIES = 16,
    parameter int PART_BYTES  = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  owner_id,
    input  logic [15:0] size_bytes,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  start_index,
    input  logic [7:0]  head,
    output ring_ctl_t   ring_ctl
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_ENTRIES - 1);
    localparam logic [ACC_W-1:0] PART_INC = ACC_W'(PART_BYTES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] start_reg, start_next;
    logic [IDX_W-1:0] run_start_reg, run_start_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             mode_reg, mode_next;
    logic [7:0]       owner_reg, owner_next;
    logic [15:0]      bytes_reg, bytes_next;
    logic [1:0]       status_reg, status_next;
    logic [3:0]       start_index_reg, start_index_next;

    logic             last;
    logic             head_free;
    logic             head_match;
    logic [ACC_W-1:0] add_a;
    logic [ACC_W:0]   add_sum;
    logic [ACC_W-1:0] acc_inc;
    logic [ACC_W-1:0] bytes_ext;

    assign last       = (idx_reg == IDX_LAST);
    assign head_free  = (head == FREE_CODE);
    assign head_match = (head == owner_reg);
    assign bytes_ext  = {1'b0, bytes_reg};

    // A free request counts bytes from zero at the first matching entry.
    assign add_a   = (state_reg == S_SCAN && mode_reg == MODE_FREE && !found_reg)
                     ? '0 : acc_reg;
    assign add_sum = {1'b0, add_a} + {1'b0, PART_INC};
    assign acc_inc = add_sum[ACC_W] ? '1 : add_sum[ACC_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        found_next       = found_reg;
        idx_next         = idx_reg;
        start_next       = start_reg;
        run_start_next   = run_start_reg;
        acc_next         = acc_reg;
        mode_next        = mode_reg;
        owner_next       = owner_reg;
        bytes_next       = bytes_reg;
        status_next      = status_reg;
        start_index_next = start_index_reg;
        ring_ctl         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next      = mode;
                    owner_next     = owner_id;
                    bytes_next     = size_bytes;
                    idx_next       = '0;
                    acc_next       = '0;
                    found_next     = 1'b0;
                    start_next     = '0;
                    run_start_next = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ring_ctl.shift = 1'b1;
                if (mode_reg == MODE_ALLOC)
                begin
                    if (head_free)
                    begin
                        acc_next = acc_inc;
                        if (acc_reg == '0)
                        begin
                            run_start_next = idx_reg;
                        end
                        if (!found_reg && acc_inc >= bytes_ext)
                        begin
                            found_next = 1'b1;
                            start_next = (acc_reg == '0) ? idx_reg : run_start_reg;
                        end
                    end
                    else
                    begin
                        acc_next = '0;
                    end
                end
                else
                begin
                    if (found_reg || head_match)
                    begin
                        acc_next       = acc_inc;
                        ring_ctl.wr    = (add_a < bytes_ext);
                        ring_ctl.wdata = FREE_CODE;
                        if (!found_reg)
                        begin
                            found_next = 1'b1;
                            start_next = idx_reg;
                        end
                    end
                end
                idx_next = last ? '0 : idx_reg + 1'b1;
                if (last)
                begin
                    if (mode_reg == MODE_ALLOC && found_next)
                    begin
                        acc_next   = '0;
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WRITE:
            begin
                ring_ctl.shift = 1'b1;
                ring_ctl.wdata = owner_reg;
                if (idx_reg >= start_reg)
                begin
                    ring_ctl.wr = (acc_reg < bytes_ext);
                    acc_next    = acc_inc;
                end
                idx_next = last ? '0 : idx_reg + 1'b1;
                if (last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        status_next      = ST_OK;
                        start_index_next = 4'(start_reg);
                    end
                    else
                    begin
                        status_next      = (mode_reg == MODE_ALLOC) ? ST_NO_SPACE
                                                                    : ST_NOT_FOUND;
                        start_index_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg       <= start_next;
        run_start_reg   <= run_start_next;
        acc_reg         <= acc_next;
        mode_reg        <= mode_next;
        owner_reg       <= owner_next;
        bytes_reg       <= bytes_next;
        status_reg      <= status_next;
        start_index_reg <= start_index_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign start_index = start_index_reg;

    // A free request finishes after its single pass over the ring.
    a_free_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && last && mode_reg == MODE_FREE) |=> state_reg == S_DONE)
        else $error("free request did not finish after one pass");

    // Entries change only in the write pass or while clearing an owner.
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        ring_ctl.wr |-> ring_ctl.shift &&
            (state_reg == S_WRITE || (state_reg == S_SCAN && mode_reg == MODE_FREE)))
        else $error("table write outside a write window");

    // Allocation writes only a found run, from its start onwards.
    a_alloc_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && ring_ctl.wr) |-> found_reg && idx_reg >= start_reg)
        else $error("allocation wrote outside the found run");

    // A new result is loaded only on leaving the done state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared without a finished request");

endmodule

// ===== src/first_fit_partition_allocator.sv =====
// Top level of the first-fit partition allocator: ring of table cells and sequencer.
`timescale 1ns / 1ps

// The block keeps an owner table of NUM_ENTRIES partitions of PART_BYTES bytes.
// A request word (mode, owner_id, size_bytes) is taken on the input channel when
// in_valid and in_ready are both high; exactly one result word (status,
// start_index) follows on the output channel, held until out_ready takes it.
// The table lives in a ring of cells that rotates one entry per cycle, while a
// request scans or writes it, past a single head, where the sequencer compares
// and rewrites entries; one full turn of the ring returns every entry to its
// own cell. A free request needs one turn, finding the owner and clearing
// behind it. An allocate request needs one turn to find the lowest fitting
// run and, when found, a second turn to tag it. A new request is taken the
// cycle after the previous result is loaded, so the block takes no new
// request until the last one is through its turns of the ring. The result
// register lets a request be accepted while the previous result waits; if
// the receiver stalls, a finished request waits in its last state and
// in_ready stays low. Reset marks every entry free.

module first_fit_partition_allocator
    import ffpa_pkg::*;
#(
    parameter int NUM_ENTRIES = 16,
    parameter int PART_BYTES  = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  owner_id,
    input  logic [15:0] size_bytes,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  start_index
);

    ring_ctl_t  ring_ctl;
    logic [7:0] cell_q [NUM_ENTRIES];
    logic [7:0] tail_in;

    // The head entry goes to the tail unchanged unless the sequencer rewrites it.
    assign tail_in = ring_ctl.wr ? ring_ctl.wdata : cell_q[0];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_ENTRIES; gi++)
        begin : g_cell
            ffpa_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (ring_ctl.shift),
                .d     ((gi == NUM_ENTRIES - 1) ? tail_in : cell_q[(gi + 1) % NUM_ENTRIES]),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    ffpa_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .PART_BYTES  (PART_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .owner_id    (owner_id),
        .size_bytes  (size_bytes),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .start_index (start_index),
        .head        (cell_q[0]),
        .ring_ctl    (ring_ctl)
    );

endmodule

// ===== tb/sv/first_fit_partition_allocator_tb.sv =====
// Self-checking testbench for the first-fit partition allocator, with driver, monitor and shadow table.
`timescale 1ns / 1ps

// The testbench keeps its own copy of the owner table and predicts each
// result when a request word is accepted. A clocked driver presents request
// words from a queue that the initial block fills. A clocked monitor takes
// result words and compares them, field by field, with the oldest prediction.
// The stimulus opens with a directed sequence. It covers zero sizes, a full
// table, the free code used as an owner, clamped and partial frees, and
// requests larger than the table. Random traffic follows, drawn from a small
// pool of owners so that frees mostly find something to release.

module first_fit_partition_allocator_tb;

    import ffpa_pkg::*;

    localparam int NUM_ENTRIES      = 16;
    localparam int PART_BYTES       = 1024;
    localparam int RANDOM_ITEMS     = 925;
    localparam int SECOND_DRAIN_AT  = 600;     // random item that waits for an empty block
    localparam int CALM_ITEMS       = 120;     // final stretch with no idling on either side
    localparam int LONG_HOLD_AT     = 400;     // results seen before the long receiver stall
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 4 * NUM_ENTRIES + 40;
    localparam int LIMIT_CYCLES     = 400000;

    // One request word, plus a flag that makes the driver wait for an empty block.
    typedef struct {
        logic        mode;
        logic [7:0]  owner;
        logic [15:0] size;
        bit          drain;
    } request_t;

    typedef struct {
        logic [1:0] status;
        logic [3:0] start;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = MODE_ALLOC;
    logic [7:0]  owner_id = 8'd0;
    logic [15:0] size_bytes = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [3:0]  start_index;

    // Shadow of the owner table and the predicted results still to arrive.
    logic [7:0] shadow_table [NUM_ENTRIES];
    request_t   request_queue [$];
    result_t    awaited_results [$];
    request_t   current_req = '{mode: MODE_ALLOC, owner: 8'd0, size: 16'd0, drain: 1'b0};

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  results_seen = 0;
    int  alloc_count = 0;
    int  free_count = 0;
    int  granted_count = 0;
    int  no_room_count = 0;
    int  unknown_owner_count = 0;
    int  drain_count = 0;
    int  send_gap = 0;
    int  hold_left = 0;
    bit  calm = 1'b0;
    bit  long_hold_done = 1'b0;

    first_fit_partition_allocator #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .PART_BYTES  (PART_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .owner_id    (owner_id),
        .size_bytes  (size_bytes),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .start_index (start_index)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one request to the shadow table and returns the result the
    // block must give for it. Allocation looks for the lowest run of free
    // entries that fits wholly inside the table. A zero-size allocation still
    // needs one free entry to point at, although it writes nothing. Freeing
    // starts at the lowest entry that carries the owner tag and stops at the
    // end of the table.
    function automatic result_t apply_request(request_t req);
        result_t res;
        int      parts;
        int      span;
        int      first_idx;
        int      i;
        int      k;
        bit      fits;
        res.status = ST_OK;
        res.start  = 4'd0;
        first_idx  = -1;
        parts      = (int'(req.size) + PART_BYTES - 1) / PART_BYTES;
        if (req.mode == MODE_ALLOC)
        begin
            alloc_count++;
            span = (parts == 0) ? 1 : parts;
            for (i = 0; i + span <= NUM_ENTRIES && first_idx < 0; i++)
            begin
                fits = 1'b1;
                for (k = 0; k < span; k++)
                    if (shadow_table[i + k] != FREE_CODE)
                        fits = 1'b0;
                if (fits)
                    first_idx = i;
            end
            if (first_idx >= 0)
            begin
                for (k = 0; k < parts; k++)
                    shadow_table[first_idx + k] = req.owner;
            end
            else
                res.status = ST_NO_SPACE;
        end
        else
        begin
            free_count++;
            for (i = 0; i < NUM_ENTRIES && first_idx < 0; i++)
                if (shadow_table[i] == req.owner)
                    first_idx = i;
            if (first_idx >= 0)
            begin
                for (k = 0; k < parts && first_idx + k < NUM_ENTRIES; k++)
                    shadow_table[first_idx + k] = FREE_CODE;
            end
            else
                res.status = ST_NOT_FOUND;
        end
        if (first_idx >= 0)
            res.start = first_idx[3:0];
        case (res.status)
            ST_OK:       granted_count++;
            ST_NO_SPACE: no_room_count++;
            default:     unknown_owner_count++;
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_request(input logic m, input logic [7:0] o, input logic [15:0] s,
                                 input bit d);
        request_t req;
        req.mode  = m;
        req.owner = o;
        req.size  = s;
        req.drain = d;
        request_queue.push_back(req);
    endtask

    // Random request. Most owners come from a small pool so that frees usually
    // find an owner. Most sizes are a few partitions, so the table keeps
    // churning instead of staying full.
    function automatic request_t random_request(bit d);
        request_t req;
        int       r;
        req.drain = d;
        req.mode  = ($urandom_range(0, 99) < 55) ? MODE_ALLOC : MODE_FREE;
        r = $urandom_range(0, 99);
        if (r < 8)
            req.owner = 8'($urandom_range(0, 255));
        else if (r < 12)
            req.owner = FREE_CODE;
        else
            req.owner = 8'($urandom_range(1, 5));
        r = $urandom_range(0, 99);
        if (req.mode == MODE_ALLOC)
        begin
            if (r < 70)
                req.size = 16'($urandom_range(0, 4 * PART_BYTES));
            else if (r < 85)
                req.size = 16'($urandom_range(0, NUM_ENTRIES * PART_BYTES));
            else if (r < 92)
                req.size = 16'($urandom_range(1, 8) * PART_BYTES);
            else
                req.size = 16'($urandom_range(0, 65535));
        end
        else
        begin
            if (r < 60)
                req.size = 16'($urandom_range(0, 4 * PART_BYTES));
            else if (r < 75)
                req.size = 16'd0;
            else if (r < 90)
                req.size = 16'hFFFF;
            else
                req.size = 16'($urandom_range(0, 65535));
        end
        return req;
    endfunction

    // Driver. A word stays on the port until it is accepted. Between words
    // it may sometimes idle. A word marked for
    // draining is held back until every predicted result has been taken.
    always @(posedge clk)
    begin
        bit fire;
        bit offer;
        if (rst_n)
        begin
            fire = in_valid && in_ready;
            if (fire)
                awaited_results.push_back(apply_request(current_req));
            offer = in_valid && !fire;
            calm  = (request_queue.size() < CALM_ITEMS);
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (!calm && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(0, 7);
                else if (request_queue.size() > 0 &&
                         !(request_queue[0].drain && awaited_results.size() != 0))
                begin
                    current_req = request_queue.pop_front();
                    if (current_req.drain)
                        drain_count++;
                    offer = 1'b1;
                end
            end
            in_valid   <= offer;
            mode       <= current_req.mode;
            owner_id   <= current_req.owner;
            size_bytes <= current_req.size;
        end
    end

    // Monitor. It checks each result word taken against the oldest prediction.
    // It stalls in random bursts. Once, part way through, it holds off for a
    // long stretch while the driver keeps offering, so the block backs up.
    always @(posedge clk)
    begin
        result_t want;
        bit      take;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                    flag_mismatch("result with nothing awaited, status", status, -1);
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                        flag_mismatch("status", status, want.status);
                    if (start_index !== want.start)
                        flag_mismatch("start_index", start_index, want.start);
                end
            end
            take = 1'b1;
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else if (!long_hold_done && results_seen >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES - 1;
                take           = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(0, 7);
                take      = 1'b0;
            end
            out_ready <= take;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("first_fit_partition_allocator verification failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        for (n = 0; n < NUM_ENTRIES; n++)
            shadow_table[n] = FREE_CODE;

        // Directed opening on an empty table.
        queue_request(MODE_ALLOC, 8'd1,    16'd0,     1'b0); // zero size: lowest free entry only
        queue_request(MODE_ALLOC, 8'd1,    16'd1,     1'b0); // one byte rounds up to a partition
        queue_request(MODE_ALLOC, 8'd2,    16'd1024,  1'b0);
        queue_request(MODE_ALLOC, 8'd3,    16'd1025,  1'b0); // two partitions
        queue_request(MODE_ALLOC, 8'd4,    16'hFFFF,  1'b0); // far larger than the table
        queue_request(MODE_ALLOC, 8'd5,    16'd16384, 1'b0); // whole table, but some is taken
        queue_request(MODE_FREE,  8'd9,    16'd1024,  1'b0); // owner not present
        queue_request(MODE_FREE,  8'd3,    16'd0,     1'b0); // zero size free clears nothing
        queue_request(MODE_FREE,  8'd3,    16'd1024,  1'b0); // partial free of a two-entry run
        queue_request(MODE_ALLOC, FREE_CODE, 16'd2048, 1'b0); // free code as owner
        queue_request(MODE_FREE,  FREE_CODE, 16'd1024, 1'b0); // matches the lowest free entry
        queue_request(MODE_FREE,  8'd3,    16'hFFFF,  1'b0); // clear clamped at the table end
        queue_request(MODE_FREE,  8'd1,    16'hFFFF,  1'b0);
        queue_request(MODE_FREE,  8'd2,    16'hFFFF,  1'b0);
        queue_request(MODE_ALLOC, 8'hFF,   16'd16384, 1'b0); // fills the whole table
        queue_request(MODE_ALLOC, 8'd7,    16'd0,     1'b0); // zero size on a full table
        queue_request(MODE_FREE,  8'hFF,   16'd15360, 1'b0); // leaves the last entry owned
        queue_request(MODE_ALLOC, 8'h00,   16'd15360, 1'b0);
        queue_request(MODE_FREE,  8'hFF,   16'd3072,  1'b0); // from the last entry, clamped
        queue_request(MODE_ALLOC, 8'hAA,   16'd1024,  1'b0);
        queue_request(MODE_FREE,  8'h00,   16'hFFFF,  1'b0); // sweeps through another owner
        queue_request(MODE_ALLOC, 8'h55,   16'd16385, 1'b0); // one partition over the table
        queue_request(MODE_FREE,  8'hAA,   16'd1024,  1'b0);
        queue_request(MODE_ALLOC, 8'd1,    16'd16384, 1'b0);
        queue_request(MODE_FREE,  8'd1,    16'd16384, 1'b0);

        // Random traffic. The first word and one later word wait for an empty block.
        for (n = 0; n < RANDOM_ITEMS; n++)
            request_queue.push_back(random_request(n == 0 || n == SECOND_DRAIN_AT));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            flag_mismatch("results never delivered", 0, awaited_results.size());

        $display("Covered %0d requests (%0d allocate, %0d free): %0d granted, %0d without room, %0d with an unknown owner.",
                 alloc_count + free_count, alloc_count, free_count,
                 granted_count, no_room_count, unknown_owner_count);
        $display("Output held off for %0d cycles once; input waited for an empty block %0d times.",
                 LONG_HOLD_CYCLES, drain_count);
        if (mismatch_count == 0)
            $display("first_fit_partition_allocator verification clean");
        else
            $display("first_fit_partition_allocator verification failed");
        $finish;
    end

endmodule
